// ----- hw/rtl/mi3_pkg.sv -----
// shared types, widths and saturation helper for the 3x3 matrix inverse
package mi3_pkg;

   localparam int DATA_W = 32;
   localparam int LANES  = 9;
   localparam int COF_W  = 65;
   localparam int MAG_W  = 64;
   localparam int DET_W  = 97;
   localparam int DMAG_W = 96;
   localparam int QUO_W  = 32;
   localparam int SAT_W  = 97;

   typedef logic [LANES-1:0][DATA_W-1:0] mat_type;
   typedef logic [LANES-1:0][COF_W-1:0]  cof_type;
   typedef logic [LANES-1:0][MAG_W-1:0]  cmag_type;

   typedef struct packed {
      logic valid;
      logic transpose;
   } ctl_type;

   typedef struct packed {
      mat_type             mat;
      logic [DATA_W-1:0]   det;
      logic                singular;
   } side_type;

   // sign plus magnitude to saturated 32-bit two's complement
   function automatic logic [DATA_W-1:0] sat32(input logic neg, input logic [SAT_W-1:0] mag);
      logic [DATA_W-1:0] res;
      if (neg) begin
         if (mag > SAT_W'(33'h0_8000_0000)) res = 32'h8000_0000;
         else res = DATA_W'(-mag[DATA_W-1:0]);
      end else begin
         if (mag > SAT_W'(33'h0_7FFF_FFFF)) res = 32'h7FFF_FFFF;
         else res = mag[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/mi3_req_if.sv -----
// request channel: one input matrix per beat
interface mi3_req_if import mi3_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

   modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
   modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

// ----- hw/rtl/mi3_rsp_if.sv -----
// response channel: result matrix, determinant and singular flag per beat
interface mi3_rsp_if import mi3_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic signed [DATA_W-1:0] determinant;
   logic singular;

   modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, determinant,
                  singular, input ready);
   modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, determinant,
                singular, output ready);
endinterface

// ----- hw/rtl/mi3_cof.sv -----
// cofactor stages: 18 products, then nine full precision cofactors
module mi3_cof import mi3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  ctl_type ctl,
   input  mat_type mat,
   output ctl_type cof_ctl,
   output mat_type cof_mat,
   output cof_type cof
);

   // element indexes of the two products of each cofactor: pa0*pa1 - pb0*pb1
   localparam int unsigned IDX [LANES][4] = '{
      '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
      '{7, 2, 8, 1}, '{8, 0, 6, 2}, '{6, 1, 7, 0},
      '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
   };

   ctl_type ctl_p_ff, ctl_c_ff;
   mat_type mat_p_ff, mat_c_ff;
   logic signed [2*DATA_W-1:0] pa_ff [LANES];
   logic signed [2*DATA_W-1:0] pb_ff [LANES];
   cof_type cof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff <= '0;
         ctl_c_ff <= '0;
      end else if (en) begin
         ctl_p_ff <= ctl;
         ctl_c_ff <= ctl_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mat_p_ff <= mat;
         mat_c_ff <= mat_p_ff;
         for (int k = 0; k < LANES; k++) begin
            pa_ff[k] <= $signed(mat[IDX[k][0]]) * $signed(mat[IDX[k][1]]);
            pb_ff[k] <= $signed(mat[IDX[k][2]]) * $signed(mat[IDX[k][3]]);
            cof_ff[k] <= COF_W'(pa_ff[k]) - COF_W'(pb_ff[k]);
         end
      end
   end

   assign cof_ctl = ctl_c_ff;
   assign cof_mat = mat_c_ff;
   assign cof     = cof_ff;

endmodule

// ----- hw/rtl/mi3_det.sv -----
// determinant stages: split products along row 0, recombine, sum
module mi3_det import mi3_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  ctl_type                 ctl,
   input  mat_type                 mat,
   input  cof_type                 cof,
   output ctl_type                 det_ctl,
   output mat_type                 det_mat,
   output cof_type                 det_cof,
   output logic signed [DET_W-1:0] det
);

   localparam int STG = 3;

   ctl_type ctl_ff [STG];
   mat_type mat_ff [STG];
   cof_type cof_ff [STG];
   logic signed [2*DATA_W+1:0] plo_ff [3];
   logic signed [2*DATA_W-1:0] phi_ff [3];
   logic signed [DET_W-1:0]    term_ff [3];
   logic signed [DET_W-1:0]    det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STG; s++) ctl_ff[s] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl;
         for (int s = 1; s < STG; s++) ctl_ff[s] <= ctl_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff[0] <= mat;
         cof_ff[0] <= cof;
         for (int s = 1; s < STG; s++) begin
            mat_ff[s] <= mat_ff[s-1];
            cof_ff[s] <= cof_ff[s-1];
         end
         for (int j = 0; j < 3; j++) begin
            // cofactor = signed high 32 bits * 2^33 + unsigned low 33 bits
            plo_ff[j] <= $signed(mat[j]) * $signed({1'b0, cof[j][32:0]});
            phi_ff[j] <= $signed(mat[j]) * $signed(cof[j][COF_W-1:33]);
            term_ff[j] <= $signed({phi_ff[j], 33'b0}) + DET_W'(plo_ff[j]);
         end
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
      end
   end

   assign det_ctl = ctl_ff[STG-1];
   assign det_mat = mat_ff[STG-1];
   assign det_cof = cof_ff[STG-1];
   assign det     = det_ff;

endmodule

// ----- hw/rtl/mi3_div.sv -----
// nine-lane restoring divider, one quotient bit per stage, with saturation
module mi3_div import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld,
   input  cmag_type          mag,
   input  logic [LANES-1:0]  neg,
   input  logic [DMAG_W-1:0] dmag,
   input  side_type          side,
   output logic              res_vld,
   output mat_type           res,
   output side_type          res_side
);

   localparam int NW  = (2*FRAC_BITS + 65 > DMAG_W) ? 2*FRAC_BITS + 66 : DMAG_W + 1;
   localparam int CW  = NW + QUO_W + 1;
   localparam int DW  = DMAG_W + 1;
   localparam int STG = QUO_W + 1;

   logic              a_vld_ff;
   logic [NW-1:0]     a_num_ff [LANES];
   logic [DW-1:0]     a_dsr_ff;
   logic [LANES-1:0]  a_neg_ff;
   side_type          a_side_ff;

   logic              vld_ff  [STG];
   logic [NW-1:0]     rem_ff  [STG][LANES];
   logic [QUO_W-1:0]  quo_ff  [STG][LANES];
   logic [LANES-1:0]  ovf_ff  [STG];
   logic [LANES-1:0]  neg_ff  [STG];
   logic [DW-1:0]     dsr_ff  [STG];
   side_type          side_ff [STG];

   logic [NW-1:0]     rem_in  [STG][LANES];
   logic [LANES-1:0]  bit_in  [STG];

   logic              out_vld_ff;
   mat_type           res_ff;
   side_type          out_side_ff;

   // stage zero checks for a quotient of 2^32 or more, later stages take one bit each
   always_comb begin
      logic [CW-1:0] shd;
      for (int l = 0; l < LANES; l++) begin
         bit_in[0][l] = CW'(a_num_ff[l]) >= (CW'(a_dsr_ff) << QUO_W);
         rem_in[0][l] = a_num_ff[l];
      end
      for (int s = 1; s < STG; s++) begin
         shd = CW'(dsr_ff[s-1]) << (QUO_W - s);
         for (int l = 0; l < LANES; l++) begin
            bit_in[s][l] = CW'(rem_ff[s-1][l]) >= shd;
            rem_in[s][l] = bit_in[s][l] ? rem_ff[s-1][l] - shd[NW-1:0] : rem_ff[s-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int s = 0; s < STG; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         a_vld_ff  <= vld;
         vld_ff[0] <= a_vld_ff;
         for (int s = 1; s < STG; s++) vld_ff[s] <= vld_ff[s-1];
         out_vld_ff <= vld_ff[STG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // numerator 2*|c|*2^(2f) + |d| over 2*|d| rounds half away from zero
         for (int l = 0; l < LANES; l++)
            a_num_ff[l] <= (NW'(mag[l]) << (2*FRAC_BITS + 1)) + NW'(dmag);
         a_dsr_ff  <= {dmag, 1'b0};
         a_neg_ff  <= neg;
         a_side_ff <= side;

         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= rem_in[0][l];
            quo_ff[0][l] <= '0;
         end
         ovf_ff[0]  <= bit_in[0];
         neg_ff[0]  <= a_neg_ff;
         dsr_ff[0]  <= a_dsr_ff;
         side_ff[0] <= a_side_ff;

         for (int s = 1; s < STG; s++) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               quo_ff[s][l] <= quo_ff[s-1][l] | (QUO_W'(bit_in[s][l]) << (QUO_W - s));
            end
            ovf_ff[s]  <= ovf_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            dsr_ff[s]  <= dsr_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end

         for (int l = 0; l < LANES; l++)
            res_ff[l] <= sat32(neg_ff[STG-1][l],
                               SAT_W'({ovf_ff[STG-1][l], quo_ff[STG-1][l]}));
         out_side_ff <= side_ff[STG-1];
      end
   end

   assign res_vld  = out_vld_ff;
   assign res      = res_ff;
   assign res_side = out_side_ff;

endmodule

// ----- hw/rtl/matrix3_inverse.sv -----
// pipeline: 43 register stages from the accepting edge to the earliest response beat
// throughput: one matrix per cycle; the 33 quotient stages and multiplier stages are all pipelined
// a stalled response holds the whole pipeline, so req ready follows rsp ready combinationally
// reset (synchronous, active high) clears every stage valid bit and transpose_result
// payload registers are not reset
module matrix3_inverse import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   mi3_req_if.sink            req,
   mi3_rsp_if.source          rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // register index sits at paddr[2]
   localparam logic CSR_TRANSPOSE = 1'b0;

   // 0 gives the rows of the adjugate order, 1 the transposed order
   localparam int unsigned TIDX [LANES] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

   // global advance: everything moves unless the output beat is stuck
   logic advance;

   // config register
   logic transpose_ff;

   // input stage
   ctl_type in_ctl_ff;
   mat_type in_mat_ff;
   mat_type req_mat;

   // cofactor and determinant stages
   ctl_type cof_ctl;
   mat_type cof_mat;
   cof_type cof;
   ctl_type det_ctl;
   mat_type det_mat;
   cof_type det_cof;
   logic signed [DET_W-1:0] det;

   // prep stage: magnitudes and signs for the divider, rounded determinant
   logic              prep_vld_ff;
   cmag_type          prep_mag_ff, prep_mag_in;
   logic [LANES-1:0]  prep_neg_ff, prep_neg_in;
   logic [DMAG_W-1:0] prep_dmag_ff, prep_dmag_in;
   side_type          prep_side_ff, prep_side_in;

   // divider results
   logic     div_vld;
   mat_type  div_res;
   side_type div_side;

   // output beat register
   logic              rsp_vld_ff;
   mat_type           rsp_mat_ff, rsp_mat_in;
   logic [DATA_W-1:0] rsp_det_ff;
   logic              rsp_sing_ff;

   assign advance   = !rsp_vld_ff || rsp.ready;
   assign req.ready = advance;

   // apb register port, always ready
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_TRANSPOSE) ? {31'b0, transpose_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         transpose_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && paddr[2] == CSR_TRANSPOSE) begin
         transpose_ff <= pwdata[0];
      end
   end

   // element k is row k/3, column k%3
   assign req_mat = {req.a22, req.a21, req.a20, req.a12, req.a11, req.a10,
                     req.a02, req.a01, req.a00};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else if (advance) begin
         in_ctl_ff.valid     <= req.valid;
         in_ctl_ff.transpose <= transpose_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) in_mat_ff <= req_mat;
   end

   mi3_cof u_cof (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .ctl     (in_ctl_ff),
      .mat     (in_mat_ff),
      .cof_ctl (cof_ctl),
      .cof_mat (cof_mat),
      .cof     (cof)
   );

   mi3_det u_det (
      .clock   (clock),
      .reset   (reset),
      .en      (advance),
      .ctl     (cof_ctl),
      .mat     (cof_mat),
      .cof     (cof),
      .det_ctl (det_ctl),
      .det_mat (det_mat),
      .det_cof (det_cof),
      .det     (det)
   );

   // prep: |det|, rounded determinant, pick cofactor order, split sign and magnitude
   always_comb begin
      logic [DET_W-1:0] dneg;
      logic [SAT_W-1:0] dround;
      logic [COF_W-1:0] c;
      logic [COF_W-1:0] cneg;
      dneg         = DET_W'(-det);
      prep_dmag_in = det[DET_W-1] ? dneg[DMAG_W-1:0] : det[DMAG_W-1:0];
      dround       = (SAT_W'(prep_dmag_in) + (SAT_W'(1) << (2*FRAC_BITS - 1)))
                     >> (2*FRAC_BITS);
      prep_side_in.mat      = det_mat;
      prep_side_in.det      = sat32(det[DET_W-1], dround);
      prep_side_in.singular = (det == '0);
      for (int k = 0; k < LANES; k++) begin
         c                 = det_ctl.transpose ? det_cof[k] : det_cof[TIDX[k]];
         cneg              = COF_W'(-c);
         prep_neg_in[k]    = c[COF_W-1] ^ det[DET_W-1];
         prep_mag_in[k]    = c[COF_W-1] ? cneg[MAG_W-1:0] : c[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (advance) begin
         prep_vld_ff <= det_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_mag_ff  <= prep_mag_in;
         prep_neg_ff  <= prep_neg_in;
         prep_dmag_ff <= prep_dmag_in;
         prep_side_ff <= prep_side_in;
      end
   end

   mi3_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .vld      (prep_vld_ff),
      .mag      (prep_mag_ff),
      .neg      (prep_neg_ff),
      .dmag     (prep_dmag_ff),
      .side     (prep_side_ff),
      .res_vld  (div_vld),
      .res      (div_res),
      .res_side (div_side)
   );

   // singular matrices pass through unchanged
   assign rsp_mat_in = div_side.singular ? div_side.mat : div_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mat_ff  <= rsp_mat_in;
         rsp_det_ff  <= div_side.det;
         rsp_sing_ff <= div_side.singular;
      end
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.r00         = rsp_mat_ff[0];
   assign rsp.r01         = rsp_mat_ff[1];
   assign rsp.r02         = rsp_mat_ff[2];
   assign rsp.r10         = rsp_mat_ff[3];
   assign rsp.r11         = rsp_mat_ff[4];
   assign rsp.r12         = rsp_mat_ff[5];
   assign rsp.r20         = rsp_mat_ff[6];
   assign rsp.r21         = rsp_mat_ff[7];
   assign rsp.r22         = rsp_mat_ff[8];
   assign rsp.determinant = rsp_det_ff;
   assign rsp.singular    = rsp_sing_ff;

`ifndef SYNTHESIS
   // a singular beat always reports a zero determinant
   a_sing_det: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.singular |-> rsp.determinant == '0)
      else $error("singular beat with nonzero determinant");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid after reset");

   // the mode register changes only on a write
   a_csr_hold: assert property (@(posedge clock) disable iff (reset)
      !(psel && penable && pwrite) |=> $stable(transpose_ff))
      else $error("transpose_result changed without a write");
`endif

endmodule

// ----- bench/mi3_tb_pkg.sv -----
// testbench constants and types for the matrix inverse bench
`timescale 1ns / 100ps
package mi3_tb_pkg;

   typedef enum logic [2:0] {
      REG_TRANSPOSE = 3'd0
   } reg_addr_type;

   typedef struct {
      logic signed [31:0] a[9];
   } matrix_type;

   typedef struct {
      logic signed [31:0] r[9];
      logic signed [31:0] det;
      logic               singular;
   } inverse_type;

endpackage

// ----- bench/mi3_inverse_checker.sv -----
// checker: predicts each inverse from the request beats and compares response beats
`timescale 1ns / 100ps
module mi3_inverse_checker import mi3_tb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   mi3_req_if       req,
   mi3_rsp_if       rsp,
   input  logic     transpose_mode,
   output int       fail_count,
   output int       pending_count,
   output int       result_count,
   output int       singular_count
);

   inverse_type expected_q[$];

   function automatic logic [31:0] saturate(input logic neg, input logic [255:0] mag);
      if (neg) begin
         if (mag > 256'h8000_0000) return 32'h8000_0000;
         return 32'(-mag[31:0]);
      end
      if (mag > 256'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return mag[31:0];
   endfunction

   function automatic inverse_type predict_inverse(input matrix_type m, input logic tr);
      inverse_type res;
      logic signed [255:0] x[3][3];
      logic signed [255:0] cof[3][3];
      logic signed [255:0] det, c;
      logic [255:0] dmag, cmag, quo;
      x[0][0] = m.a[0]; x[0][1] = m.a[1]; x[0][2] = m.a[2];
      x[1][0] = m.a[3]; x[1][1] = m.a[4]; x[1][2] = m.a[5];
      x[2][0] = m.a[6]; x[2][1] = m.a[7]; x[2][2] = m.a[8];
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            cof[i][j] = x[(i+1)%3][(j+1)%3] * x[(i+2)%3][(j+2)%3]
                      - x[(i+1)%3][(j+2)%3] * x[(i+2)%3][(j+1)%3];
      det = x[0][0]*cof[0][0] + x[0][1]*cof[0][1] + x[0][2]*cof[0][2];
      if (det == 0) begin
         // singular: matrix passes through
         for (int k = 0; k < 9; k++) res.r[k] = m.a[k];
         res.det = 0;
         res.singular = 1'b1;
         return res;
      end
      dmag = (det < 0) ? -det : det;
      res.det = saturate(det < 0, (dmag + (256'd1 << 31)) >> 32);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            c = tr ? cof[i][j] : cof[j][i];
            cmag = (c < 0) ? -c : c;
            // round half away from zero on the magnitude
            quo = (((cmag << 32) << 1) + dmag) / (dmag << 1);
            res.r[i*3+j] = saturate(((c < 0) != (det < 0)) && quo != 0, quo);
         end
      res.singular = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      matrix_type m;
      inverse_type e;
      logic [31:0] got[9];
      if (reset) begin
         fail_count = 0;
         pending_count = 0;
         result_count = 0;
         singular_count = 0;
      end else begin
         if (req.valid && req.ready) begin
            m.a = '{req.a00, req.a01, req.a02, req.a10, req.a11, req.a12,
                    req.a20, req.a21, req.a22};
            expected_q.push_back(predict_inverse(m, transpose_mode));
         end
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (expected_q.size() == 0) begin
               $display("%0t response beat with nothing expected", $time);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               got = '{rsp.r00, rsp.r01, rsp.r02, rsp.r10, rsp.r11, rsp.r12,
                       rsp.r20, rsp.r21, rsp.r22};
               for (int k = 0; k < 9; k++)
                  if (got[k] !== e.r[k])
                     report_mismatch($sformatf("r%0d%0d", k/3, k%3), got[k], e.r[k]);
               if (rsp.determinant !== e.det)
                  report_mismatch("determinant", rsp.determinant, e.det);
               if (rsp.singular !== e.singular)
                  report_mismatch("singular", rsp.singular, e.singular);
               if (e.singular) singular_count++;
            end
         end
         pending_count = expected_q.size();
      end
   end

endmodule

// ----- bench/tb.sv -----
// testbench top: clock, reset, stimulus, register writes and verdict
`timescale 1ns / 100ps
module tb import mi3_tb_pkg::*; ();

   localparam int LATENCY = 43;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // mirror of the transpose register, updated at the write edge
   logic transpose_mode = 1'b0;

   // idle percentages for the current phase
   int send_idle = 0;
   int recv_stall = 0;

   int fail_count, pending_count, result_count, singular_count;
   int sent_count = 0;
   int idle_cycles = 0;

   mi3_req_if req();
   mi3_rsp_if rsp();

   matrix3_inverse u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   mi3_inverse_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .transpose_mode(transpose_mode), .fail_count(fail_count),
      .pending_count(pending_count), .result_count(result_count),
      .singular_count(singular_count)
   );

   always #5 clock = ~clock;

   // receiver: random stall per the current phase, idle in reset
   always @(posedge clock) begin
      if (reset)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= ($urandom_range(99) >= recv_stall);
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // one register write: setup cycle then access cycle
   task automatic write_reg(input reg_addr_type addr, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // register takes the value at this edge
      transpose_mode <= value[0];
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // wait for every expected response, then let the pipe drain
   task automatic drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // present one matrix, hold until accepted; optional idle gap first
   task automatic send_matrix(input matrix_type m);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      {req.a00, req.a01, req.a02, req.a10, req.a11, req.a12, req.a20, req.a21, req.a22}
         <= {m.a[0], m.a[1], m.a[2], m.a[3], m.a[4], m.a[5], m.a[6], m.a[7], m.a[8]};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic stop_sending();
      req.valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_element(input int kind);
      logic [31:0] v;
      case (kind)
         0: v = $urandom();
         1: v = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
         2: v = 32'($signed($urandom_range(0, 64)) - 32);
         3: v = 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
         default: begin
            case ($urandom_range(3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic matrix_type rand_matrix();
      matrix_type m;
      int kind;
      int shape;
      kind = $urandom_range(4);
      for (int k = 0; k < 9; k++)
         m.a[k] = ($urandom_range(9) == 0) ? rand_element($urandom_range(4))
                                           : rand_element(kind);
      shape = $urandom_range(9);
      // duplicated row or column gives an exactly singular matrix
      if (shape == 0) for (int j = 0; j < 3; j++) m.a[6+j] = m.a[j];
      if (shape == 1) for (int i = 0; i < 3; i++) m.a[3*i+2] = m.a[3*i];
      // mostly diagonal: well conditioned inverse
      if (shape == 2) begin
         for (int k = 0; k < 9; k++) if (k % 4 != 0) m.a[k] = rand_element(2);
      end
      return m;
   endfunction

   function automatic matrix_type fill(input logic [31:0] v0, v1, v2, v3, v4, v5, v6, v7,
                                       v8);
      matrix_type m;
      m.a = '{v0, v1, v2, v3, v4, v5, v6, v7, v8};
      return m;
   endfunction

   task automatic run_directed();
      localparam logic [31:0] ONE = 32'h0001_0000;
      localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
      localparam logic [31:0] MINV = 32'h8000_0000;
      // identity
      send_matrix(fill(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
      // zero matrix: singular pass-through
      send_matrix(fill(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // non-symmetric: transpose vs plain differs
      send_matrix(fill(2*ONE, ONE, 0, 0, ONE, 3*ONE, ONE, 0, ONE));
      // extremes on the diagonal
      send_matrix(fill(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
      send_matrix(fill(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
      send_matrix(fill(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV));
      // extremes in two equal rows, singular
      send_matrix(fill(MAXV, MINV, MAXV, MAXV, MINV, MAXV, 1, 2, 3));
      // tiny determinant: rounds to zero but stays regular, inverse saturates
      send_matrix(fill(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(fill(32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 1));
      // determinant that overflows Q16.16
      send_matrix(fill(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000));
      // negative scaled matrix, rounding ties
      send_matrix(fill(3*ONE, 0, 0, 0, 32'hFFFD_0000, 0, 0, 0, 7*ONE));
      send_matrix(fill(2, 0, 0, 0, 2, 0, 0, 0, 32'h0000_0001));
      // permutation matrix
      send_matrix(fill(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
      // all ones bit pattern on the diagonal, mixed patterns elsewhere
      send_matrix(fill(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                       32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h8765_4321,
                       32'hFFFF_FFFF));
      stop_sending();
   endtask

   task automatic run_random(input int count, input int sidle, input int rstall);
      send_idle = sidle;
      recv_stall = rstall;
      for (int n = 0; n < count; n++) send_matrix(rand_matrix());
      stop_sending();
   endtask

   initial begin
      req.valid = 1'b0;
      {req.a00, req.a01, req.a02, req.a10, req.a11, req.a12, req.a20, req.a21, req.a22} = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain inverse, directed corners in both modes
      write_reg(REG_TRANSPOSE, 32'h0);
      run_directed();
      drain();
      // upper bits of the write are ignored, only bit 0 sets the mode
      write_reg(REG_TRANSPOSE, 32'hFFFF_FFFF);
      run_directed();
      drain();

      run_random(400, 0, 0);
      drain();
      write_reg(REG_TRANSPOSE, 32'h0);
      run_random(380, 74, 0);
      drain();
      write_reg(REG_TRANSPOSE, 32'h1);
      run_random(380, 0, 74);
      // hold off until every response has come back
      drain();
      write_reg(REG_TRANSPOSE, 32'h0);
      run_random(360, 30, 30);
      drain();

      $display("sent %0d matrices in both modes and four idle phases", sent_count);
      $display("checked %0d responses, %0d singular", result_count, singular_count);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_req_if.sv
hw/rtl/mi3_rsp_if.sv
hw/rtl/mi3_cof.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div.sv
hw/rtl/matrix3_inverse.sv
bench/mi3_tb_pkg.sv
bench/mi3_inverse_checker.sv
bench/tb.sv
